[rtl/mouse_look_direction_defines.svh]
// Assertion macros for the mouse-look direction RTL, used by mld_back.
`ifndef MOUSE_LOOK_DIRECTION_DEFINES_SVH
`define MOUSE_LOOK_DIRECTION_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define MLD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the cycle of its antecedent.
`define MLD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/mld_pkg.sv]
// Types, constants and trigonometry helpers of the mouse-look direction block.
package mld_pkg;

  // Register indexes on the configuration port
  localparam logic REG_SENSITIVITY = 1'b0;

  localparam logic [3:0] SENS_RESET    = 4'd2;
  localparam int unsigned PREV_RESET   = 387;
  localparam logic [8:0] HEADING_RESET = 9'd270;
  localparam logic signed [7:0] ELEV_RESET = 8'sd90;

  localparam int unsigned DEG_90   = 90;
  localparam int unsigned DEG_180  = 180;
  localparam int unsigned DEG_270  = 270;
  localparam int unsigned DEG_360  = 360;
  localparam int unsigned ELEV_MAX = 89;

  // floor(2^24 / 360): quotient estimate is exact or one short
  localparam int unsigned RECIP_M     = 46603;
  localparam int unsigned RECIP_SHIFT = 24;

  localparam int unsigned Q_FRAC     = 14;
  localparam int unsigned ROUND_HALF = 8192;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  // round(16384 * sin(d degrees)), d = 0..90
  localparam logic [14:0] SINE_Q14 [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Sign and magnitude of a Q2.14 value
  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
  } sm_t;

  // One result word
  typedef struct packed {
    logic signed [7:0]  elevation_deg;
    logic [8:0]         heading_deg;
    logic signed [15:0] dir_z;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_x;
  } result_t;

  function automatic logic [14:0] sine_lookup(input logic [6:0] idx);
    logic [14:0] v;
    v = (idx > 7'(DEG_90)) ? 15'd0 : SINE_Q14[idx];
    return v;
  endfunction

  // Sine of a heading 0..359, folded onto the first quadrant
  function automatic sm_t sin_of(input logic [8:0] h);
    sm_t        s;
    logic [8:0] idx;
    if (h < 9'(DEG_90)) begin
      idx = h;
      s.neg = 1'b0;
    end else if (h < 9'(DEG_180)) begin
      idx = 9'(DEG_180) - h;
      s.neg = 1'b0;
    end else if (h < 9'(DEG_270)) begin
      idx = h - 9'(DEG_180);
      s.neg = 1'b1;
    end else begin
      idx = 9'(DEG_360) - h;
      s.neg = 1'b1;
    end
    s.mag = sine_lookup(idx[6:0]);
    return s;
  endfunction

endpackage

[rtl/mld_front.sv]
// Input side: track the previous cursor position and form raw movements.
module mld_front import mld_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COORD_BITS-1:0]    cursor_x,
  input  logic [COORD_BITS-1:0]    cursor_y,
  input  logic                     queue_full,
  output logic                     push,
  output logic [2*COORD_BITS+1:0]  push_data      // dx low, dy high
);

  logic                  awaiting_first;
  logic [COORD_BITS-1:0] prev_x;
  logic [COORD_BITS-1:0] prev_y;
  logic [COORD_BITS-1:0] ref_x;
  logic [COORD_BITS-1:0] ref_y;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // First word seeds the reference, so both movements are zero
  assign ref_x = awaiting_first ? cursor_x : prev_x;
  assign ref_y = awaiting_first ? cursor_y : prev_y;
  assign dx = $signed({1'b0, cursor_x}) - $signed({1'b0, ref_x});
  assign dy = $signed({1'b0, ref_y}) - $signed({1'b0, cursor_y});
  assign push_data = {dy, dx};

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first <= 1'b1;
      prev_x <= COORD_BITS'(PREV_RESET);
      prev_y <= COORD_BITS'(PREV_RESET);
    end else if (push) begin
      awaiting_first <= 1'b0;
      prev_x <= cursor_x;
      prev_y <= cursor_y;
    end
  end

endmodule

[rtl/mld_queue.sv]
// Short first-in first-out queue between the input and the angle pipeline.
module mld_queue import mld_pkg::*; #(
  parameter int WIDTH = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] data
);

  logic [WIDTH-1:0]       mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_pop;

  assign full   = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign valid  = (count != '0);
  assign data   = mem[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/mld_back.sv]
// Angle pipeline: scale, wrap, clamp, look up sines and form the direction.
module mld_back import mld_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [3:0]              sensitivity,
  input  logic                    q_valid,
  input  logic [2*COORD_BITS+1:0] q_data,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output result_t                 out_word
);

`include "mouse_look_direction_defines.svh"

  localparam int DW    = COORD_BITS + 1;   // raw movement
  localparam int PW    = COORD_BITS + 5;   // scaled movement, signed
  localparam int MAG_W = COORD_BITS + 4;   // scaled magnitude
  localparam int QW    = COORD_BITS - 4;   // quotient by 360
  localparam int EW    = PW + 1;           // elevation sum

  logic [7:0] vld;
  logic       adv;

  // stage 1: scale
  logic signed [DW-1:0] dx_c;
  logic signed [DW-1:0] dy_c;
  logic signed [PW-1:0] px_c;
  logic [MAG_W-1:0]     mag1;
  logic                 neg1;
  logic signed [PW-1:0] py1;
  // stage 2: quotient estimate
  logic [MAG_W+15:0]    prod_c;
  logic [QW-1:0]        q2;
  logic [MAG_W-1:0]     mag2;
  logic                 neg2;
  logic signed [PW-1:0] py2;
  // stage 3: raw remainder
  logic [MAG_W-1:0]     r0_c;
  logic [9:0]           r3;
  logic                 neg3;
  logic signed [PW-1:0] py3;
  // stage 4: signed heading step
  logic [8:0]           rfix_c;
  logic signed [9:0]    sr4;
  logic signed [PW-1:0] py4;
  // stage 5: angle state
  logic [8:0]           heading;
  logic [8:0]           heading_next;
  logic signed [7:0]    elevation;
  logic signed [7:0]    elevation_next;
  logic signed [10:0]   hsum_c;
  logic signed [EW-1:0] esum_c;
  // stage 6: table look-ups
  logic [8:0]           hcos_c;
  logic [6:0]           eabs_c;
  sm_t                  sh6;
  sm_t                  ch6;
  logic [14:0]          ce6;
  logic signed [15:0]   se6;
  logic [8:0]           h6;
  logic signed [7:0]    e6;
  // stage 7: products
  logic [29:0]          mx_c;
  logic [29:0]          mz_c;
  sm_t                  mx7;
  sm_t                  mz7;
  logic signed [15:0]   se7;
  logic [8:0]           h7;
  logic signed [7:0]    e7;

  // Advance the whole pipeline unless the output word is held
  assign adv       = !vld[7] || out_ready;
  assign pop       = adv;
  assign out_valid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], q_valid};
    end
  end

  assign dx_c = q_data[DW-1:0];
  assign dy_c = q_data[2*DW-1:DW];
  assign px_c = PW'($signed(dx_c) * $signed({1'b0, sensitivity}));

  assign prod_c = (MAG_W+16)'(mag1) * (MAG_W+16)'(RECIP_M);
  assign r0_c   = mag2 - MAG_W'(q2) * MAG_W'(DEG_360);
  assign rfix_c = (r3 >= 10'(DEG_360)) ? 9'(r3 - 10'(DEG_360)) : r3[8:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      neg1 <= px_c[PW-1];
      mag1 <= px_c[PW-1] ? MAG_W'(-px_c) : MAG_W'(px_c);
      py1  <= PW'($signed(dy_c) * $signed({1'b0, sensitivity}));

      q2   <= prod_c[RECIP_SHIFT +: QW];
      mag2 <= mag1;
      neg2 <= neg1;
      py2  <= py1;

      r3   <= r0_c[9:0];
      neg3 <= neg2;
      py3  <= py2;

      sr4  <= neg3 ? -$signed({1'b0, rfix_c}) : $signed({1'b0, rfix_c});
      py4  <= py3;
    end
  end

  // Wrap the heading into 0..359 and clamp the elevation to +/-89
  always_comb begin
    hsum_c = $signed({2'b00, heading}) + $signed({sr4[9], sr4});
    if (hsum_c < 0) begin
      heading_next = 9'(hsum_c + 11'sd360);
    end else if (hsum_c >= 11'sd360) begin
      heading_next = 9'(hsum_c - 11'sd360);
    end else begin
      heading_next = hsum_c[8:0];
    end
    esum_c = $signed({{(EW-8){elevation[7]}}, elevation}) + $signed({py4[PW-1], py4});
    if (esum_c > $signed(EW'(ELEV_MAX))) begin
      elevation_next = 8'(ELEV_MAX);
    end else if (esum_c < -$signed(EW'(ELEV_MAX))) begin
      elevation_next = -8'sd89;
    end else begin
      elevation_next = esum_c[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading   <= HEADING_RESET;
      elevation <= ELEV_RESET;
    end else if (adv && vld[3]) begin
      heading   <= heading_next;
      elevation <= elevation_next;
    end
  end

  assign hcos_c = (heading >= 9'(DEG_270)) ? heading - 9'(DEG_270) : heading + 9'(DEG_90);
  assign eabs_c = elevation[7] ? 7'(-elevation) : elevation[6:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      sh6 <= sin_of(heading);
      ch6 <= sin_of(hcos_c);
      ce6 <= sine_lookup(7'(DEG_90) - eabs_c);
      se6 <= elevation[7] ? -$signed({1'b0, sine_lookup(eabs_c)})
                          : $signed({1'b0, sine_lookup(eabs_c)});
      h6  <= heading;
      e6  <= elevation;
    end
  end

  // Round magnitudes half up, apply the sign afterwards
  assign mx_c = 30'(ch6.mag) * 30'(ce6) + 30'(ROUND_HALF);
  assign mz_c = 30'(sh6.mag) * 30'(ce6) + 30'(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (adv) begin
      mx7.neg <= ch6.neg;
      mx7.mag <= mx_c[Q_FRAC +: 15];
      mz7.neg <= sh6.neg;
      mz7.mag <= mz_c[Q_FRAC +: 15];
      se7 <= se6;
      h7  <= h6;
      e7  <= e6;

      out_word.dir_x <= mx7.neg ? -$signed({1'b0, mx7.mag}) : $signed({1'b0, mx7.mag});
      out_word.dir_z <= mz7.neg ? -$signed({1'b0, mz7.mag}) : $signed({1'b0, mz7.mag});
      out_word.dir_y <= se7;
      out_word.heading_deg   <= h7;
      out_word.elevation_deg <= e7;
    end
  end

  `MLD_ASSERT_ALWAYS(a_heading_range, heading < 9'(DEG_360), "heading left 0..359")
  `MLD_ASSERT_IMPLY(a_elev_clamped, vld[4], (elevation <= 8'sd89) && (elevation >= -8'sd89),
    "elevation not clamped after update")
  `MLD_ASSERT_IMPLY(a_step_range, vld[3], (sr4 < 10'sd360) && (sr4 > -10'sd360),
    "heading step out of range")

endmodule

[rtl/mouse_look_direction.sv]
// Top level of the mouse-look view direction block.
//
// Usage: each word on the slave stream is one cursor position (tdata: cursor_x
// low, cursor_y above). The first word after reset only seeds the previous
// position. Each word turns the heading by dx times the sensitivity (wrapped
// to 0..359) and the elevation by the upward movement times the sensitivity
// (clamped to -89..89), then gives one master word: a unit view direction in
// Q2.14 with the heading and elevation in whole degrees.
// Throughput: one word per cycle while m_tready does not stall the pipeline;
// every stage of the angle pipeline and the queue in front of it is fully
// pipelined, the only loop being the heading and elevation update.
// A 4-word queue separates the input side from the pipeline, so s_tready
// stays high while the master side stalls until the queue fills.
// When m_tvalid is high and m_tready low, the whole pipeline holds and m_tdata stays stable.
// Reset: sensitivity 2, heading 270, elevation 90 (clamped to 89 on the first
// word), queue and pipeline empty. Sensitivity lives at byte address 0 on APB;
// the user writes it only while the block is idle; the block does not check.
module mouse_look_direction import mld_pkg::*; #(
  parameter  int COORD_BITS = 12,
  localparam int S_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // slave stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // cursor_x, cursor_y, zero pad
  // master stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [71:0]          m_tdata    // dir_x, dir_y, dir_z, heading_deg,
                                          // elevation_deg, zero pad
);

  localparam int QW_DATA = 2 * (COORD_BITS + 1);

  logic [3:0]         sensitivity;
  logic               cfg_write;
  logic               queue_full;
  logic               push;
  logic [QW_DATA-1:0] push_data;
  logic               q_valid;
  logic [QW_DATA-1:0] q_data;
  logic               pop;
  result_t            out_word;

  // Configuration: accept every access at once, keep the low 4 bits
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity <= SENS_RESET;
    end else if (cfg_write && (paddr[2] == REG_SENSITIVITY)) begin
      sensitivity <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_SENSITIVITY) ? {28'd0, sensitivity} : 32'd0;

  // Front: seed and difference cursor positions
  mld_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .cursor_x   (s_tdata[COORD_BITS-1:0]),
    .cursor_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Decouple the two sides
  mld_queue #(
    .WIDTH (QW_DATA)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  // Back: angle update and direction
  mld_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .sensitivity (sensitivity),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_word    (out_word)
  );

  // Pad the 65-bit result to whole bytes
  assign m_tdata = {7'd0, out_word};

endmodule

[verif/mouse_look_direction_checker.sv]
// Checker for the mouse-look direction block: predicts each result word and compares it.
module mouse_look_direction_checker import mld_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // cursor_x, cursor_y
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // dir_x, dir_y, dir_z, heading_deg, elevation_deg, zero pad
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] SENS_ADDR = {REG_SENSITIVITY, 2'b00};

  int        sine_tab [0:90];
  logic [3:0]  turn_rate;
  logic        seeding;
  logic [11:0] last_x;
  logic [11:0] last_y;
  int          heading;
  int          elevation;
  result_t     pending_looks [$];

  // Build the quarter-wave table from true pi
  initial begin
    for (int d = 0; d <= 90; d++)
      sine_tab[d] = $rtoi(16384.0 * $sin(d * 3.14159265358979 / 180.0) + 0.5);
    mismatches = 0;
    outstanding = 0;
  end

  // Sine of 0..359 degrees in Q2.14, folded onto the first quadrant
  function automatic int sine_q14(int a);
    int q;
    int r;
    q = a / 90;
    r = a % 90;
    case (q)
      0:       return sine_tab[r];
      1:       return sine_tab[90 - r];
      2:       return -sine_tab[r];
      default: return -sine_tab[90 - r];
    endcase
  endfunction

  // Magnitudes multiplied and rounded half up, sign applied afterwards
  function automatic int q14_product(int a, int b);
    int m;
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 8192) >> 14;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  // Turn the view by one cursor word and give the resulting direction
  function automatic result_t advance_look(logic [11:0] x, logic [11:0] y);
    result_t r;
    int      dx;
    int      dy;
    int      e_abs;
    int      sin_e;
    int      cos_e;
    if (seeding) begin
      last_x = x;
      last_y = y;
      seeding = 1'b0;
    end
    dx = (int'(x) - int'(last_x)) * int'(turn_rate);
    dy = (int'(last_y) - int'(y)) * int'(turn_rate);
    last_x = x;
    last_y = y;
    heading = (heading + dx) % 360;
    if (heading < 0) heading += 360;
    elevation += dy;
    if (elevation > 89) elevation = 89;
    if (elevation < -89) elevation = -89;
    e_abs = elevation < 0 ? -elevation : elevation;
    sin_e = elevation < 0 ? -sine_tab[e_abs] : sine_tab[e_abs];
    cos_e = sine_tab[90 - e_abs];
    r.dir_x = 16'(q14_product(sine_q14((heading + 90) % 360), cos_e));
    r.dir_y = 16'(sin_e);
    r.dir_z = 16'(q14_product(sine_q14(heading), cos_e));
    r.heading_deg = 9'(heading);
    r.elevation_deg = 8'(elevation);
    return r;
  endfunction

  task automatic report(string field, int want, int got);
    $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      turn_rate = 4'd2;
      seeding = 1'b1;
      last_x = 12'd387;
      last_y = 12'd387;
      heading = 270;
      elevation = 90;
      pending_looks.delete();
    end else begin
      // Track register writes; other addresses hold nothing
      if (psel && penable && pwrite && pready && paddr == SENS_ADDR)
        turn_rate = pwdata[3:0];
      if (s_tvalid && s_tready)
        pending_looks.push_back(advance_look(s_tdata[11:0], s_tdata[23:12]));
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[64:0]);
        if (pending_looks.size() == 0) begin
          $display("%0t unexpected result word, actual %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = pending_looks.pop_front();
          if (got.dir_x !== want.dir_x) report("dir_x", want.dir_x, got.dir_x);
          if (got.dir_y !== want.dir_y) report("dir_y", want.dir_y, got.dir_y);
          if (got.dir_z !== want.dir_z) report("dir_z", want.dir_z, got.dir_z);
          if (got.heading_deg !== want.heading_deg)
            report("heading_deg", want.heading_deg, got.heading_deg);
          if (got.elevation_deg !== want.elevation_deg)
            report("elevation_deg", want.elevation_deg, got.elevation_deg);
        end
      end
    end
    outstanding = pending_looks.size();
  end

endmodule

[verif/tb_mouse_look_direction.sv]
// Testbench top for the mouse-look direction block: stimulus, stalls and verdict.
module tb_mouse_look_direction;
  timeunit 1ns;
  timeprecision 1ps;
  import mld_pkg::*;

  localparam logic [2:0] SENS_ADDR  = {REG_SENSITIVITY, 2'b00};
  localparam logic [2:0] SPARE_ADDR = 3'd4;   // no register behind it
  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASE_WORDS    = 305;
  localparam int HOLD_OFF_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // cursor_x, cursor_y
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;         // dir_x, dir_y, dir_z, heading_deg, elevation_deg, zero pad

  int          mismatches;
  int          outstanding;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  logic [11:0] cur_x;
  logic [11:0] cur_y;

  mouse_look_direction DUT (.*);

  mouse_look_direction_checker look_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .mismatches, .outstanding
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch when asked so that
  // the input queue fills and the block drops s_tready
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      m_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one cursor word, idling first at random; valid stays high into the
  // next word when no gap follows
  task automatic send_cursor(logic [11:0] x, logic [11:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    cur_x = x;
    cur_y = y;
  endtask

  // Register write: setup, then access
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Hold until every expected word has come back, then let the pipeline settle
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Mostly small cursor walks, with some jumps and fully random positions
  task automatic random_cursor();
    int kind;
    logic [11:0] x;
    logic [11:0] y;
    kind = $urandom_range(99);
    if (kind < 75) begin
      x = cur_x + 12'($urandom_range(120) - 60);
      y = cur_y + 12'($urandom_range(10) - 5);
    end else if (kind < 90) begin
      x = cur_x + 12'($urandom_range(1000) - 500);
      y = cur_y + 12'($urandom_range(200) - 100);
    end else begin
      x = 12'($urandom);
      y = 12'($urandom);
    end
    send_cursor(x, y);
  endtask

  initial begin
    int          sens_list [6] = '{15, 1, 0, 7, 0, 3};
    int          idle_list [6] = '{0, 52, 0, 21, 0, 21};
    int          stall_list [6] = '{0, 0, 52, 21, 0, 21};
    logic [31:0] value;

    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed words at the reset sensitivity: seed, quadrant corners, clamps,
    // coordinate extremes and a zero movement
    send_cursor(12'd2048, 12'd2048);
    send_cursor(12'd2093, 12'd2048);
    send_cursor(12'd2138, 12'd2048);
    send_cursor(12'd2183, 12'd2048);
    send_cursor(12'd2228, 12'd2048);
    send_cursor(12'd2229, 12'd2048);
    send_cursor(12'd2228, 12'd2093);
    send_cursor(12'd2228, 12'd2048);
    send_cursor(12'd2228, 12'd2092);
    send_cursor(12'd2228, 12'd2093);
    send_cursor(12'd0, 12'd0);
    send_cursor(12'd4095, 12'd4095);
    send_cursor(12'd0, 12'd4095);
    send_cursor(12'd4095, 12'd0);
    send_cursor(12'd4095, 12'd0);
    send_cursor(12'd4094, 12'd1);
    send_cursor(12'd0, 12'd0);
    send_cursor(12'd1, 12'd4095);
    send_cursor(12'd2730, 12'd1365);
    send_cursor(12'd1365, 12'd2730);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      // Mix junk into the unused upper bits; the fifth phase picks at random
      value = $urandom;
      value[3:0] = (p == 4) ? 4'($urandom_range(15, 1)) : 4'(sens_list[p]);
      write_reg(SENS_ADDR, value);
      if (p == 3) write_reg(SPARE_ADDR, $urandom);
      send_idle_pct = idle_list[p];
      recv_stall_pct = stall_list[p];
      if (p == 0) hold_req = 1'b1;
      repeat (PHASE_WORDS) random_cursor();
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
